// File: rtl/jrs_pkg.sv
// Shared types and constants for the jump unit with return-address stack.
`default_nettype none

package jrs_pkg;

  // Field widths
  localparam int OP_W   = 3;
  localparam int ADDR_W = 32;

  // Default return stack depth
  localparam int STACK_DEPTH_DEF = 4;

  // Jump kinds
  localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
  localparam logic [OP_W-1:0] OP_J      = 3'd1;
  localparam logic [OP_W-1:0] OP_JAL    = 3'd2;
  localparam logic [OP_W-1:0] OP_JR     = 3'd3;
  localparam logic [OP_W-1:0] OP_CALL   = 3'd4;
  localparam logic [OP_W-1:0] OP_RETURN = 3'd5;

  // Shift control broadcast to every stack cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/jrs_cell.sv
// One return stack cell: holds an entry and its occupancy bit, shifts with its neighbors.
`default_nettype none

module jrs_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire jrs_pkg::cell_ctrl_t       ctrl,
  input  wire logic [jrs_pkg::ADDR_W-1:0] up_data,
  input  wire logic                      up_occ,
  input  wire logic [jrs_pkg::ADDR_W-1:0] down_data,
  input  wire logic                      down_occ,
  output logic [jrs_pkg::ADDR_W-1:0]     data,
  output logic                           occ
);
  import jrs_pkg::*;

  // Occupancy: push takes the upper neighbor, pop takes the lower one
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.push) begin
      occ <= up_occ;
    end else if (ctrl.pop) begin
      occ <= down_occ;
    end
  end

  // Entry payload, no reset
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      data <= up_data;
    end else if (ctrl.pop) begin
      data <= down_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/jump_unit_with_return_stack.sv
// Top level: jump decode, output register and the return stack cell chain.
//
// Usage: one decoded instruction enters per request on the input channel
// (in_valid/in_stall) with operation, imm_target, reg_value, pc_plus_four.
// Each request gives exactly one result on the output channel
// (out_valid/out_stall): redirect, target, flush_fetch, link_select and the
// sticky overflow_error/underflow_error flags.
// The result is registered at the edge that accepts the request. Throughput
// is one request per cycle unless the receiver stalls; the limit is the
// single output register, which is refilled in the same cycle it is taken.
// The return stack is a chain of STACK_DEPTH cells; cell 0 is the top. A
// call shifts the chain down by one cell, a return shifts it up (unless
// full or empty), both in the accepting cycle, so the next request sees
// the updated stack. The request after any jump is a bubble and gives an
// all-quiet result. Reset (rst, synchronous) empties the stack, clears the
// bubble and both sticky flags, and drops any pending result. When the
// receiver stalls, the result holds and in_stall rises until it is taken.
`default_nettype none

module jump_unit_with_return_stack #(
  parameter int STACK_DEPTH = jrs_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [jrs_pkg::OP_W-1:0]   operation,
  input  wire logic [jrs_pkg::ADDR_W-1:0] imm_target,
  input  wire logic [jrs_pkg::ADDR_W-1:0] reg_value,
  input  wire logic [jrs_pkg::ADDR_W-1:0] pc_plus_four,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            redirect,
  output logic [jrs_pkg::ADDR_W-1:0]      target,
  output logic                            flush_fetch,
  output logic                            link_select,
  output logic                            overflow_error,
  output logic                            underflow_error
);
  import jrs_pkg::*;

  logic                    in_acc;
  logic                    bubble_pending;
  logic                    full;
  logic                    empty;
  logic                    jump;
  logic                    link;
  logic [ADDR_W-1:0]       tgt;
  cell_ctrl_t              ctrl;
  logic [ADDR_W-1:0]       cell_data [STACK_DEPTH];
  logic [STACK_DEPTH-1:0]  cell_occ;

  // Input handshake: take a request when the output register is free or draining
  assign in_stall = out_valid & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  assign full  = cell_occ[STACK_DEPTH-1];
  assign empty = ~cell_occ[0];

  // Decode
  always_comb begin
    jump      = 1'b0;
    link      = 1'b0;
    tgt       = '0;
    ctrl.push = 1'b0;
    ctrl.pop  = 1'b0;
    if (!bubble_pending) begin
      case (operation)
        OP_J: begin
          jump = 1'b1;
          tgt  = imm_target;
        end
        OP_JAL: begin
          jump = 1'b1;
          link = 1'b1;
          tgt  = imm_target;
        end
        OP_JR: begin
          jump = 1'b1;
          tgt  = reg_value;
        end
        OP_CALL: begin
          jump      = 1'b1;
          tgt       = imm_target;
          ctrl.push = in_acc & ~full;
        end
        OP_RETURN: begin
          jump     = 1'b1;
          tgt      = empty ? '0 : cell_data[0];
          ctrl.pop = in_acc & ~empty;
        end
        default: begin
          jump = 1'b0;
        end
      endcase
    end
  end

  // Return stack cell chain, cell 0 is top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [ADDR_W-1:0] up_data;
    logic              up_occ;
    logic [ADDR_W-1:0] down_data;
    logic              down_occ;

    if (i == 0) begin : g_top
      assign up_data = pc_plus_four;
      assign up_occ  = 1'b1;
    end else begin : g_mid
      assign up_data = cell_data[i-1];
      assign up_occ  = cell_occ[i-1];
    end

    if (i == STACK_DEPTH-1) begin : g_bot
      assign down_data = cell_data[i];
      assign down_occ  = 1'b0;
    end else begin : g_low
      assign down_data = cell_data[i+1];
      assign down_occ  = cell_occ[i+1];
    end

    jrs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .up_data   (up_data),
      .up_occ    (up_occ),
      .down_data (down_data),
      .down_occ  (down_occ),
      .data      (cell_data[i]),
      .occ       (cell_occ[i])
    );
  end

  // Control state: bubble, sticky flags, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      bubble_pending  <= 1'b0;
      overflow_error  <= 1'b0;
      underflow_error <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (in_acc) begin
        bubble_pending <= jump;
        if (!bubble_pending && operation == OP_CALL && full) begin
          overflow_error <= 1'b1;
        end
        if (!bubble_pending && operation == OP_RETURN && empty) begin
          underflow_error <= 1'b1;
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      redirect    <= jump;
      target      <= tgt;
      flush_fetch <= jump;
      link_select <= link;
    end
  end

  // Checks
  a_push_pop_excl : assert property (@(posedge clk) disable iff (rst)
    !(ctrl.push && ctrl.pop))
    else $error("push and pop in the same cycle");

  a_occ_thermo : assert property (@(posedge clk) disable iff (rst)
    (cell_occ & (cell_occ + STACK_DEPTH'(1))) == '0)
    else $error("stack occupancy is not contiguous from the top");

  a_bubble_quiet : assert property (@(posedge clk) disable iff (rst)
    (in_acc && bubble_pending) |=> (out_valid && !redirect && !link_select))
    else $error("request after a jump was not a bubble");

  a_ovf_sticky : assert property (@(posedge clk) disable iff (rst)
    overflow_error |=> overflow_error)
    else $error("overflow flag cleared without reset");

  a_unf_sticky : assert property (@(posedge clk) disable iff (rst)
    underflow_error |=> underflow_error)
    else $error("underflow flag cleared without reset");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the jump unit with its return-address stack.

module tb_top;
  import jrs_pkg::*;

  localparam int STACK_DEPTH    = STACK_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT   = 10;
  localparam int CLEAN_ITEMS    = 800;
  localparam int NOISE_ITEMS    = 375;

  // Opcodes the block treats as not a jump
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic              redirect;
    logic [ADDR_W-1:0] target;
    logic              flush_fetch;
    logic              link_select;
    logic              overflow_error;
    logic              underflow_error;
  } jump_result_t;

  // Predicts jump results from accepted requests and checks the block's output
  class jump_scoreboard;
    logic [ADDR_W-1:0] ras [STACK_DEPTH];
    int unsigned       stack_depth;
    bit                bubble_next;
    bit                ovf_flag;
    bit                unf_flag;
    jump_result_t      expected_q [$];
    int unsigned       failures;

    function new();
      stack_depth = 0;
      bubble_next = 1'b0;
      ovf_flag    = 1'b0;
      unf_flag    = 1'b0;
      failures    = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Work out the result of one accepted request and queue it
    function void take_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] imm,
                               logic [ADDR_W-1:0] regv, logic [ADDR_W-1:0] pc);
      jump_result_t res;
      bit jump;
      res  = '0;
      jump = 1'b0;
      if (bubble_next) begin
        bubble_next = 1'b0;
      end else begin
        case (op)
          OP_J: begin
            jump = 1'b1;
            res.target = imm;
          end
          OP_JAL: begin
            jump = 1'b1;
            res.link_select = 1'b1;
            res.target = imm;
          end
          OP_JR: begin
            jump = 1'b1;
            res.target = regv;
          end
          OP_CALL: begin
            if (stack_depth < STACK_DEPTH) begin
              ras[stack_depth] = pc;
              stack_depth++;
            end else begin
              ovf_flag = 1'b1;
            end
            jump = 1'b1;
            res.target = imm;
          end
          OP_RETURN: begin
            // empty stack: still jumps, to address zero
            if (stack_depth > 0) begin
              stack_depth--;
              res.target = ras[stack_depth];
            end else begin
              unf_flag = 1'b1;
              res.target = '0;
            end
            jump = 1'b1;
          end
          default: ;
        endcase
        bubble_next = jump;
      end
      res.redirect        = jump;
      res.flush_fetch     = jump;
      res.overflow_error  = ovf_flag;
      res.underflow_error = unf_flag;
      expected_q.push_back(res);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(jump_result_t act);
      jump_result_t exp;
      bit bad;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("ERROR: result with no request pending: %p", act);
        return;
      end
      exp = expected_q.pop_front();
      bad = (act.redirect !== exp.redirect) || (act.target !== exp.target) ||
            (act.flush_fetch !== exp.flush_fetch) ||
            (act.link_select !== exp.link_select) ||
            (act.overflow_error !== exp.overflow_error) ||
            (act.underflow_error !== exp.underflow_error);
      if (bad) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("ERROR: jump result mismatch");
          $display("  expected redir=%0b tgt=%h flush=%0b link=%0b ovf=%0b unf=%0b",
                   exp.redirect, exp.target, exp.flush_fetch, exp.link_select,
                   exp.overflow_error, exp.underflow_error);
          $display("  actual   redir=%0b tgt=%h flush=%0b link=%0b ovf=%0b unf=%0b",
                   act.redirect, act.target, act.flush_fetch, act.link_select,
                   act.overflow_error, act.underflow_error);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   operation = '0;
  logic [ADDR_W-1:0] imm_target = '0;
  logic [ADDR_W-1:0] reg_value = '0;
  logic [ADDR_W-1:0] pc_plus_four = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              redirect;
  logic [ADDR_W-1:0] target;
  logic              flush_fetch;
  logic              link_select;
  logic              overflow_error;
  logic              underflow_error;

  bit                no_idle = 1'b0;
  int unsigned       quiet_cycles = 0;
  jump_scoreboard    sb = new();

  jump_unit_with_return_stack dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .imm_target      (imm_target),
    .reg_value       (reg_value),
    .pc_plus_four    (pc_plus_four),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .redirect        (redirect),
    .target          (target),
    .flush_fetch     (flush_fetch),
    .link_select     (link_select),
    .overflow_error  (overflow_error),
    .underflow_error (underflow_error)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst || no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 33);
    end
  end

  // Result checking and watchdog
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) moved = 1'b1;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        sb.check_result('{redirect, target, flush_fetch, link_select,
                          overflow_error, underflow_error});
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Drive one request and hold it until the block takes it
  task automatic send_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] imm,
                           logic [ADDR_W-1:0] regv, logic [ADDR_W-1:0] pc);
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    imm_target   <= imm;
    reg_value    <= regv;
    pc_plus_four <= pc;
    do @(posedge clk); while (in_stall);
    sb.take_request(op, imm, regv, pc);
  endtask

  task automatic send_op(logic [OP_W-1:0] op);
    send_item(op, rand_addr(), rand_addr(), rand_addr());
  endtask

  task automatic send_noise();
    send_op(OP_W'($urandom_range(0, 7)));
  endtask

  // Keeps the stack within range so most requests reach the stack logic
  task automatic send_clean();
    int unsigned r;
    logic [OP_W-1:0] op;
    r = $urandom_range(0, 99);
    if (sb.bubble_next) begin
      send_noise();
      return;
    end
    if (r < 15)      op = OP_NONE;
    else if (r < 20) op = (r[0]) ? OP_SPARE_6 : OP_SPARE_7;
    else if (r < 30) op = OP_J;
    else if (r < 40) op = OP_JAL;
    else if (r < 50) op = OP_JR;
    else if (r < 75) op = (sb.stack_depth < STACK_DEPTH) ? OP_CALL : OP_RETURN;
    else             op = (sb.stack_depth > 0) ? OP_RETURN : OP_CALL;
    send_op(op);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every opcode, bubbles ignoring their inputs
    send_item(OP_NONE, '1, '1, '1);
    send_item(OP_SPARE_6, '1, '1, '1);
    send_item(OP_SPARE_7, '1, '1, '1);
    send_item(OP_J, '0, '1, '1);
    send_item(OP_CALL, '1, '1, '1);
    send_item(OP_J, '1, '0, '0);
    send_item(OP_RETURN, '0, '0, '0);
    send_item(OP_JAL, 32'h0040_0000, '0, 32'h0040_0004);
    send_item(OP_J, '1, '1, '1);
    send_item(OP_JR, '0, '1, '0);
    send_item(OP_JR, '0, '0, '0);
    send_item(OP_CALL, $urandom, '0, '1);
    send_item(OP_RETURN, '0, '0, '0);
    send_item(OP_CALL, '1, '1, '0);
    send_noise();
    send_item(OP_CALL, '0, '0, $urandom);
    send_noise();
    send_item(OP_CALL, $urandom, '0, 32'h8000_0000);
    send_noise();
    send_item(OP_RETURN, '1, '1, '1);
    send_noise();
    send_item(OP_RETURN, '0, '0, '0);
    send_noise();

    // Random, stack kept in range; a stretch with no idling, then a drain
    for (int i = 0; i < CLEAN_ITEMS; i++) begin
      if (i == 200) no_idle <= 1'b1;
      if (i == 350) no_idle <= 1'b0;
      if (i == 400) wait_drained();
      send_clean();
    end

    // Full-stack call, then pop everything and return on an empty stack
    while (sb.stack_depth < STACK_DEPTH) begin
      if (sb.bubble_next) send_noise();
      send_op(OP_CALL);
    end
    if (sb.bubble_next) send_noise();
    send_op(OP_CALL);
    while (sb.stack_depth > 0) begin
      if (sb.bubble_next) send_noise();
      send_op(OP_RETURN);
    end
    if (sb.bubble_next) send_noise();
    send_op(OP_RETURN);

    // Random noise with unconstrained opcodes on every fourth request, clean requests between
    for (int i = 0; i < NOISE_ITEMS; i++) begin
      if (i % 4 == 0) send_noise();
      else send_clean();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
